[hw/rtl/aei_pkg.sv]
// Shared types and constants of the Lorenz Euler integrator.
package aei_pkg;

  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 24;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SIGMA = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RHO   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BETA  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TSTEP = 2'd3;

  localparam logic [WORD_BITS-1:0] SIGMA_RESET = WORD_BITS'(10 * (2 ** FRAC_BITS));
  localparam logic [WORD_BITS-1:0] RHO_RESET   = WORD_BITS'(28 * (2 ** FRAC_BITS));
  localparam logic [WORD_BITS-1:0] BETA_RESET  =
    WORD_BITS'((8 * (2 ** FRAC_BITS) + 1) / 3);
  localparam logic [FRAC_BITS-1:0] TSTEP_RESET = FRAC_BITS'((2 ** FRAC_BITS) / 100);

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [WORD_BITS+1:0] WIDE_MAX = {3'b000, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS+1:0] WIDE_MIN = {3'b111, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic [WORD_BITS-1:0] sigma;
    logic [WORD_BITS-1:0] rho;
    logic [WORD_BITS-1:0] beta;
    logic [FRAC_BITS-1:0] tstep;
  } coef_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    logic                 b_signed;
  } mul_req_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] val;
    logic                 sat;
  } sat_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BETA,
    ST_SIGMA,
    ST_RHO,
    ST_STEP_X,
    ST_STEP_Z,
    ST_STEP_Y,
    ST_SUM_Z,
    ST_SUM_Y,
    ST_DONE
  } state_t;

endpackage

[hw/rtl/aei_if.sv]
// Item channels of the Lorenz Euler integrator.
interface aei_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  op;
  logic signed [aei_pkg::WORD_BITS-1:0]  start_x;
  logic signed [aei_pkg::WORD_BITS-1:0]  start_y;
  logic signed [aei_pkg::WORD_BITS-1:0]  start_z;

  modport source (output valid, op, start_x, start_y, start_z, input ready);
  modport sink   (input valid, op, start_x, start_y, start_z, output ready);
endinterface

interface aei_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [aei_pkg::WORD_BITS-1:0]  pos_x;
  logic signed [aei_pkg::WORD_BITS-1:0]  pos_y;
  logic signed [aei_pkg::WORD_BITS-1:0]  pos_z;
  logic                                  saturated;

  modport source (output valid, pos_x, pos_y, pos_z, saturated, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, saturated, output ready);
endinterface

[hw/rtl/aei_cfg.sv]
// Coefficient and time step registers of the Lorenz Euler integrator.
module aei_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [aei_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [aei_pkg::WORD_BITS-1:0]     cfg_wdata,
  output aei_pkg::coef_t                    coef
);

  aei_pkg::coef_t coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.sigma <= aei_pkg::SIGMA_RESET;
      coef_r.rho   <= aei_pkg::RHO_RESET;
      coef_r.beta  <= aei_pkg::BETA_RESET;
      coef_r.tstep <= aei_pkg::TSTEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aei_pkg::CFG_SIGMA: coef_r.sigma <= cfg_wdata;
        aei_pkg::CFG_RHO:   coef_r.rho   <= cfg_wdata;
        aei_pkg::CFG_BETA:  coef_r.beta  <= cfg_wdata;
        aei_pkg::CFG_TSTEP: coef_r.tstep <= cfg_wdata[aei_pkg::FRAC_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign coef = coef_r;

endmodule

[hw/rtl/aei_mul.sv]
// Shared two-stage fixed-point multiplier with floor shift and saturation.
module aei_mul (
  input  logic                clk,
  input  aei_pkg::mul_req_t   req,
  output aei_pkg::sat_word_t  rsp
);

  localparam int W  = aei_pkg::WORD_BITS;
  localparam int F  = aei_pkg::FRAC_BITS;
  localparam int QW = 2 * W - F;

  logic [W-1:0]    mag_a;
  logic [W-1:0]    mag_b;
  logic            neg_b;
  logic [2*W-1:0]  prod_nxt;
  logic [2*W-1:0]  prod_r;
  logic            neg_r;
  logic [QW-1:0]   quo;
  logic [QW-1:0]   quo_rnd;
  logic [QW-1:0]   lim;
  logic            ovf;
  logic [W-1:0]    mag;
  logic [W-1:0]    res_nxt;
  logic [W-1:0]    res_r;
  logic            sat_r;

  assign neg_b    = req.b_signed & req.b[W-1];
  assign mag_a    = req.a[W-1] ? (~req.a + 1'b1) : req.a;
  assign mag_b    = neg_b ? (~req.b + 1'b1) : req.b;
  assign prod_nxt = mag_a * mag_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    neg_r  <= req.a[W-1] ^ neg_b;
  end

  // Round toward minus infinity: bump the magnitude of a negative inexact product.
  assign quo     = prod_r[2*W-1:F];
  assign quo_rnd = quo + QW'(neg_r & (|prod_r[F-1:0]));
  assign lim     = QW'(aei_pkg::WORD_MAX) + QW'(neg_r);
  assign ovf     = quo_rnd > lim;
  assign mag     = ovf ? lim[W-1:0] : quo_rnd[W-1:0];
  assign res_nxt = neg_r ? (~mag + 1'b1) : mag;

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    sat_r <= ovf;
  end

  assign rsp.val = res_r;
  assign rsp.sat = sat_r;

endmodule

[hw/rtl/attractor_euler_integrator_unit.sv]
// Lorenz forward-Euler integrator: sequencer, saturating adders and point state.
// A step item gives its result once the sequencer reaches done and the output register
// is free; no new item is taken until a step is through, set by seven products through
// one two-stage multiplier. A load item gives no result.
// Reset clears the point to zero, the output to empty and the coefficients to
// sigma 10, rho 28, beta 8/3 and time step 0.01.
module attractor_euler_integrator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [aei_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [aei_pkg::WORD_BITS-1:0]     cfg_wdata,
  aei_in_if.sink                            in_chan,
  aei_out_if.source                         out_chan
);

  localparam int W = aei_pkg::WORD_BITS;
  localparam int F = aei_pkg::FRAC_BITS;

  function automatic aei_pkg::sat_word_t clamp_wide(input logic signed [W+1:0] v);
    aei_pkg::sat_word_t r;
    r.sat = 1'b1;
    if (v > aei_pkg::WIDE_MAX) begin
      r.val = aei_pkg::WORD_MAX;
    end else if (v < aei_pkg::WIDE_MIN) begin
      r.val = aei_pkg::WORD_MIN;
    end else begin
      r.val = v[W-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic aei_pkg::sat_word_t sub_sat(input logic [W-1:0] a, input logic [W-1:0] b);
    return clamp_wide($signed({{2{a[W-1]}}, a}) - $signed({{2{b[W-1]}}, b}));
  endfunction

  function automatic aei_pkg::sat_word_t add_sat(input logic [W-1:0] a, input logic [W-1:0] b);
    return clamp_wide($signed({{2{a[W-1]}}, a}) + $signed({{2{b[W-1]}}, b}));
  endfunction

  function automatic aei_pkg::sat_word_t coef_minus(input logic [W-1:0] c,
                                                    input logic [W-1:0] v);
    return clamp_wide($signed({2'b00, c}) - $signed({{2{v[W-1]}}, v}));
  endfunction

  aei_pkg::coef_t     coef;
  aei_pkg::mul_req_t  mul_req;
  aei_pkg::sat_word_t mul_rsp;
  aei_pkg::sat_word_t r_d;
  aei_pkg::sat_word_t r_c1;
  aei_pkg::sat_word_t r_t3;
  aei_pkg::sat_word_t r_t2;
  aei_pkg::sat_word_t r_sum;
  aei_pkg::state_t    state_r, state_nxt;

  logic [W-1:0] tstep_w;
  logic [W-1:0] sum_base;
  logic         in_ready;

  logic [W-1:0] point_x_r, point_x_nxt;
  logic [W-1:0] point_y_r, point_y_nxt;
  logic [W-1:0] point_z_r, point_z_nxt;
  logic [W-1:0] d_r, d_nxt;
  logic [W-1:0] c1_r, c1_nxt;
  logic [W-1:0] h3_r, h3_nxt;
  logic [W-1:0] t3_r, t3_nxt;
  logic [W-1:0] t2_r, t2_nxt;
  logic [W-1:0] nx_r, nx_nxt;
  logic [W-1:0] ny_r, ny_nxt;
  logic [W-1:0] nz_r, nz_nxt;
  logic         sat_r, sat_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] out_x_r, out_x_nxt;
  logic [W-1:0] out_y_r, out_y_nxt;
  logic [W-1:0] out_z_r, out_z_nxt;
  logic         out_sat_r, out_sat_nxt;

  aei_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  aei_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  assign tstep_w  = {{(W-F){1'b0}}, coef.tstep};
  assign sum_base = (state_r == aei_pkg::ST_STEP_Y) ? point_x_r :
                    (state_r == aei_pkg::ST_SUM_Z)  ? point_z_r : point_y_r;

  assign r_d   = sub_sat(point_y_r, point_x_r);
  assign r_c1  = coef_minus(coef.rho, point_z_r);
  assign r_t3  = sub_sat(h3_r, mul_rsp.val);
  assign r_t2  = sub_sat(mul_rsp.val, point_y_r);
  assign r_sum = add_sat(sum_base, mul_rsp.val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aei_pkg::ST_IDLE;
      point_x_r   <= '0;
      point_y_r   <= '0;
      point_z_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      point_x_r   <= point_x_nxt;
      point_y_r   <= point_y_nxt;
      point_z_r   <= point_z_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r       <= d_nxt;
    c1_r      <= c1_nxt;
    h3_r      <= h3_nxt;
    t3_r      <= t3_nxt;
    t2_r      <= t2_nxt;
    nx_r      <= nx_nxt;
    ny_r      <= ny_nxt;
    nz_r      <= nz_nxt;
    sat_r     <= sat_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_z_r   <= out_z_nxt;
    out_sat_r <= out_sat_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    point_x_nxt   = point_x_r;
    point_y_nxt   = point_y_r;
    point_z_nxt   = point_z_r;
    d_nxt         = d_r;
    c1_nxt        = c1_r;
    h3_nxt        = h3_r;
    t3_nxt        = t3_r;
    t2_nxt        = t2_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    nz_nxt        = nz_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r & ~out_chan.ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    out_sat_nxt   = out_sat_r;
    in_ready      = 1'b0;
    mul_req       = '{a: point_x_r, b: point_y_r, b_signed: 1'b1};

    unique case (state_r)
      aei_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        d_nxt    = r_d.val;
        c1_nxt   = r_c1.val;
        if (in_chan.valid) begin
          if (in_chan.op) begin
            sat_nxt   = r_d.sat | r_c1.sat;
            state_nxt = aei_pkg::ST_BETA;
          end else begin
            point_x_nxt = in_chan.start_x;
            point_y_nxt = in_chan.start_y;
            point_z_nxt = in_chan.start_z;
          end
        end
      end
      aei_pkg::ST_BETA: begin
        mul_req   = '{a: point_z_r, b: coef.beta, b_signed: 1'b0};
        state_nxt = aei_pkg::ST_SIGMA;
      end
      aei_pkg::ST_SIGMA: begin
        mul_req   = '{a: d_r, b: coef.sigma, b_signed: 1'b0};
        h3_nxt    = mul_rsp.val;
        sat_nxt   = sat_r | mul_rsp.sat;
        state_nxt = aei_pkg::ST_RHO;
      end
      aei_pkg::ST_RHO: begin
        mul_req   = '{a: point_x_r, b: c1_r, b_signed: 1'b1};
        t3_nxt    = r_t3.val;
        sat_nxt   = sat_r | mul_rsp.sat | r_t3.sat;
        state_nxt = aei_pkg::ST_STEP_X;
      end
      aei_pkg::ST_STEP_X: begin
        mul_req   = '{a: mul_rsp.val, b: tstep_w, b_signed: 1'b0};
        sat_nxt   = sat_r | mul_rsp.sat;
        state_nxt = aei_pkg::ST_STEP_Z;
      end
      aei_pkg::ST_STEP_Z: begin
        mul_req   = '{a: t3_r, b: tstep_w, b_signed: 1'b0};
        t2_nxt    = r_t2.val;
        sat_nxt   = sat_r | mul_rsp.sat | r_t2.sat;
        state_nxt = aei_pkg::ST_STEP_Y;
      end
      aei_pkg::ST_STEP_Y: begin
        mul_req   = '{a: t2_r, b: tstep_w, b_signed: 1'b0};
        nx_nxt    = r_sum.val;
        sat_nxt   = sat_r | mul_rsp.sat | r_sum.sat;
        state_nxt = aei_pkg::ST_SUM_Z;
      end
      aei_pkg::ST_SUM_Z: begin
        nz_nxt    = r_sum.val;
        sat_nxt   = sat_r | mul_rsp.sat | r_sum.sat;
        state_nxt = aei_pkg::ST_SUM_Y;
      end
      aei_pkg::ST_SUM_Y: begin
        ny_nxt    = r_sum.val;
        sat_nxt   = sat_r | mul_rsp.sat | r_sum.sat;
        state_nxt = aei_pkg::ST_DONE;
      end
      aei_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = nx_r;
          out_y_nxt     = ny_r;
          out_z_nxt     = nz_r;
          out_sat_nxt   = sat_r;
          point_x_nxt   = nx_r;
          point_y_nxt   = ny_r;
          point_z_nxt   = nz_r;
          state_nxt     = aei_pkg::ST_IDLE;
        end
      end
      default: state_nxt = aei_pkg::ST_IDLE;
    endcase
  end

  assign in_chan.ready      = in_ready;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.pos_x     = out_x_r;
  assign out_chan.pos_y     = out_y_r;
  assign out_chan.pos_z     = out_z_r;
  assign out_chan.saturated = out_sat_r;

  a_step_reaches_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.op) |-> ##9 (state_r == aei_pkg::ST_DONE))
    else $error("step item did not reach completion on schedule");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> ($past(state_r) == aei_pkg::ST_DONE))
    else $error("result appeared without a completed step");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && !in_chan.op && !out_chan.valid) |=> !out_chan.valid)
    else $error("load item produced a result");

  a_point_held_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != aei_pkg::ST_IDLE && state_r != aei_pkg::ST_DONE) |=>
      ($stable(point_x_r) && $stable(point_y_r) && $stable(point_z_r)))
    else $error("point changed during a step");

endmodule
